// ===== hdl/snae_pkg.sv =====
// Shared constants, types and helpers for the sparse negacyclic
// autocorrelation energy block. No dependencies.
`default_nettype none

package snae_pkg;

  localparam int SEQ_LEN     = 128;
  localparam int HALF_LEN    = SEQ_LEN / 2;
  localparam int POS_W       = 7;
  localparam int UNIT_TERMS  = 6;
  localparam int HEAVY_TERMS = 3;
  localparam int NUM_TERMS   = UNIT_TERMS + HEAVY_TERMS;
  localparam int NUM_PAIRS   = NUM_TERMS * (NUM_TERMS - 1) / 2;

  // distance arithmetic must hold both a position and SEQ_LEN itself
  localparam int SEQ_BITS = $clog2(SEQ_LEN) + 1;
  localparam int D_W      = (POS_W > SEQ_BITS) ? POS_W : SEQ_BITS;
  localparam int LAG_W    = $clog2(HALF_LEN);

  localparam int WT_W  = 3;   // term weight, -2 .. 2
  localparam int CT_W  = 4;   // pair product, -4 .. 4
  localparam int C_W   = 7;   // lag value, -63 .. 63
  localparam int MAG_W = 6;   // |lag value|
  localparam int E_W   = 12;  // energy

  localparam int SUB_PAIRS = 6;
  localparam int NSUB      = (NUM_PAIRS + SUB_PAIRS - 1) / SUB_PAIRS;
  localparam int GRP       = 8;
  localparam int NGRP      = (HALF_LEN + GRP - 1) / GRP;

  localparam int ENERGY_MAX = 3969;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH = 2'd1;
  localparam logic [E_W-1:0]       WIN_LOW_RST     = 12'd2;
  localparam logic [E_W-1:0]       WIN_HIGH_RST    = 12'd6;

  typedef struct packed {
    logic                                  mode;
    logic [UNIT_TERMS-1:0][POS_W-1:0]      pos;
    logic [UNIT_TERMS-1:0]                 unit_signs;
    logic [HEAVY_TERMS-1:0][POS_W-1:0]     heavy_pos;
    logic [HEAVY_TERMS-1:0]                heavy_neg;
  } item_t;

  typedef struct packed {
    logic [LAG_W-1:0] lag;   // zero: pair dropped
    logic [CT_W-1:0]  w;     // two's complement product
  } pair_t;

  typedef struct packed {
    logic [E_W-1:0] low;
    logic [E_W-1:0] high;
  } win_cfg_t;

  function automatic logic [C_W-1:0] sext_ct(input logic [CT_W-1:0] v);
    return {{(C_W - CT_W){v[CT_W-1]}}, v};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/snae_pair_stage.sv =====
// First pipeline stage: folded lag and signed weight product of every term pair.
// Depends on snae_pkg.
`default_nettype none

module snae_pair_stage import snae_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire item_t                       in_item,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output pair_t [NUM_PAIRS-1:0]            out_pairs
);

  logic [NUM_TERMS-1:0][POS_W-1:0] tpos;
  logic [NUM_TERMS-1:0][WT_W-1:0]  twt;
  pair_t [NUM_PAIRS-1:0]           pair_c;
  logic                            adv;

  function automatic pair_t make_pair(input logic [POS_W-1:0] pa,
                                      input logic [WT_W-1:0]  wa,
                                      input logic [POS_W-1:0] pb,
                                      input logic [WT_W-1:0]  wb);
    logic [POS_W-1:0]    d;
    logic [D_W-1:0]      dx;
    logic [2*WT_W-1:0]   prod;
    logic [CT_W-1:0]     w;
    pair_t               p;
    d    = (pa > pb) ? (pa - pb) : (pb - pa);
    dx   = D_W'(d);
    prod = {{WT_W{wa[WT_W-1]}}, wa} * {{WT_W{wb[WT_W-1]}}, wb};
    w    = prod[CT_W-1:0];
    p.lag = '0;
    p.w   = '0;
    if (dx != '0 && dx != D_W'(HALF_LEN)) begin
      if (dx < D_W'(HALF_LEN)) begin
        p.lag = LAG_W'(dx);
        p.w   = w;
      end else if (dx < D_W'(SEQ_LEN)) begin
        // folded lag, negacyclic wrap flips the sign
        p.lag = LAG_W'(D_W'(SEQ_LEN) - dx);
        p.w   = CT_W'(0) - w;
      end
    end
    return p;
  endfunction

  always_comb begin
    for (int i = 0; i < UNIT_TERMS; i++) begin
      tpos[i] = in_item.pos[i];
      twt[i]  = in_item.unit_signs[i] ? 3'b111 : 3'b001;
    end
    for (int i = 0; i < HEAVY_TERMS; i++) begin
      tpos[UNIT_TERMS+i] = in_item.heavy_pos[i];
      // weight zero removes a heavy term from every pair in mode 0
      if (!in_item.mode) begin
        twt[UNIT_TERMS+i] = '0;
      end else begin
        twt[UNIT_TERMS+i] = in_item.heavy_neg[i] ? 3'b110 : 3'b010;
      end
    end
  end

  for (genvar ga = 0; ga < NUM_TERMS; ga++) begin : g_a
    for (genvar gb = ga + 1; gb < NUM_TERMS; gb++) begin : g_b
      localparam int K = ga * (2 * NUM_TERMS - ga - 1) / 2 + (gb - ga - 1);
      assign pair_c[K] = make_pair(tpos[ga], twt[ga], tpos[gb], twt[gb]);
    end
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      out_pairs <= pair_c;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/snae_lag_accum.sv =====
// Lag accumulation: partial sums per lag over small pair groups, then the
// full lag value. Two register stages. Depends on snae_pkg.
`default_nettype none

module snae_lag_accum import snae_pkg::*; (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire pair_t [NUM_PAIRS-1:0]          in_pairs,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [HALF_LEN-1:0][C_W-1:0]        out_lag
);

  logic [HALF_LEN-1:0][NSUB-1:0][C_W-1:0] part_c;
  logic [HALF_LEN-1:0][NSUB-1:0][C_W-1:0] part;
  logic                                   part_valid;
  logic [HALF_LEN-1:0][C_W-1:0]           lag_c;
  logic                                   adv_part;
  logic                                   adv_out;

  // stage A: per lag, one partial sum for each group of pairs
  always_comb begin
    for (int l = 0; l < HALF_LEN; l++) begin
      for (int s = 0; s < NSUB; s++) begin
        part_c[l][s] = '0;
        for (int i = 0; i < SUB_PAIRS; i++) begin
          if ((s * SUB_PAIRS + i) < NUM_PAIRS && l != 0 &&
              in_pairs[s*SUB_PAIRS+i].lag == LAG_W'(l)) begin
            part_c[l][s] = part_c[l][s] + sext_ct(in_pairs[s*SUB_PAIRS+i].w);
          end
        end
      end
    end
  end

  // stage B: combine partials
  always_comb begin
    for (int l = 0; l < HALF_LEN; l++) begin
      lag_c[l] = '0;
      for (int s = 0; s < NSUB; s++) begin
        lag_c[l] = lag_c[l] + part[l][s];
      end
    end
  end

  assign adv_out  = !out_valid || out_ready;
  assign adv_part = !part_valid || adv_out;
  assign in_ready = adv_part;

  always_ff @(posedge clk) begin
    if (rst) begin
      part_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (adv_part) begin
        part_valid <= in_valid;
      end
      if (adv_out) begin
        out_valid <= part_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_part && in_valid) begin
      part <= part_c;
    end
    if (adv_out && part_valid) begin
      out_lag <= lag_c;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/snae_energy_sum.sv =====
// Energy: square of each lag value, grouped sums, total and window compare.
// Three register stages, the last one is the output register. Depends on snae_pkg.
`default_nettype none

module snae_energy_sum import snae_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire win_cfg_t                    win,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [HALF_LEN-1:0][C_W-1:0] in_lag,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [E_W-1:0]                   energy,
  output logic                             flag
);

  logic [HALF_LEN-1:0][E_W-1:0] sq_c;
  logic [HALF_LEN-1:0][E_W-1:0] sq;
  logic                         sq_valid;
  logic [NGRP-1:0][E_W-1:0]     grp_c;
  logic [NGRP-1:0][E_W-1:0]     grp;
  logic                         grp_valid;
  logic [E_W-1:0]               total_c;
  logic                         adv_sq;
  logic                         adv_grp;
  logic                         adv_out;

  always_comb begin
    for (int l = 0; l < HALF_LEN; l++) begin
      logic [C_W-1:0]       neg;
      logic [MAG_W-1:0]     mag;
      logic [2*MAG_W-1:0]   wide;
      neg  = C_W'(0) - in_lag[l];
      mag  = in_lag[l][C_W-1] ? neg[MAG_W-1:0] : in_lag[l][MAG_W-1:0];
      wide = (2*MAG_W)'(mag) * (2*MAG_W)'(mag);
      sq_c[l] = E_W'(wide);
    end
  end

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_c[g] = '0;
      for (int i = 0; i < GRP; i++) begin
        if ((g * GRP + i) < HALF_LEN) begin
          grp_c[g] = grp_c[g] + sq[g*GRP+i];
        end
      end
    end
  end

  always_comb begin
    total_c = '0;
    for (int g = 0; g < NGRP; g++) begin
      total_c = total_c + grp[g];
    end
  end

  assign adv_out  = !out_valid || out_ready;
  assign adv_grp  = !grp_valid || adv_out;
  assign adv_sq   = !sq_valid || adv_grp;
  assign in_ready = adv_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid  <= 1'b0;
      grp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_sq) begin
        sq_valid <= in_valid;
      end
      if (adv_grp) begin
        grp_valid <= sq_valid;
      end
      if (adv_out) begin
        out_valid <= grp_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_sq && in_valid) begin
      sq <= sq_c;
    end
    if (adv_grp && sq_valid) begin
      grp <= grp_c;
    end
    if (adv_out && grp_valid) begin
      energy <= total_c;
      flag   <= (total_c >= win.low) && (total_c <= win.high);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sparse_negacyclic_autocorr_energy.sv =====
// Top level of the sparse negacyclic autocorrelation sidelobe energy block.
// Depends on snae_pkg, snae_pair_stage, snae_lag_accum, snae_energy_sum.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  input    | in_valid / in_ready  | mode, pos_0..pos_5, unit_sign_bits,
//           |                      | heavy_pos_0..heavy_pos_2, heavy_sign_bits
//  output   | out_valid/out_ready  | sidelobe_energy, in_window
//  config   | cfg_we               | cfg_index, cfg_data (12 bit)
//
// Six register stages: pair lags, lag partial sums, lag totals, squares,
// group sums, output register. One item per cycle is taken as long as the
// output side keeps up.
// Every stage holds its item while the stage after it is full and stalled, so
// bubbles are squeezed out and a full pipeline stalls as one.
// rst (synchronous) empties all stages and loads the window defaults 2 and 6.
`default_nettype none

module sparse_negacyclic_autocorr_energy import snae_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,

  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  mode,
  input  wire logic [POS_W-1:0]      pos_0,
  input  wire logic [POS_W-1:0]      pos_1,
  input  wire logic [POS_W-1:0]      pos_2,
  input  wire logic [POS_W-1:0]      pos_3,
  input  wire logic [POS_W-1:0]      pos_4,
  input  wire logic [POS_W-1:0]      pos_5,
  input  wire logic [UNIT_TERMS-1:0] unit_sign_bits,
  input  wire logic [POS_W-1:0]      heavy_pos_0,
  input  wire logic [POS_W-1:0]      heavy_pos_1,
  input  wire logic [POS_W-1:0]      heavy_pos_2,
  input  wire logic [HEAVY_TERMS-1:0] heavy_sign_bits,

  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [E_W-1:0]             sidelobe_energy,
  output logic                       in_window,

  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [E_W-1:0]        cfg_data
);

  item_t                        item;
  win_cfg_t                     win;

  logic                         pair_valid;
  logic                         pair_ready;
  pair_t [NUM_PAIRS-1:0]        pairs;

  logic                         lag_valid;
  logic                         lag_ready;
  logic [HALF_LEN-1:0][C_W-1:0] lags;

  // window registers; writes to unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      win.low  <= WIN_LOW_RST;
      win.high <= WIN_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_LOW:  win.low  <= cfg_data;
        REG_WINDOW_HIGH: win.high <= cfg_data;
        default: ;
      endcase
    end
  end

  // gather the input fields into one item
  always_comb begin
    item.mode           = mode;
    item.pos[0]         = pos_0;
    item.pos[1]         = pos_1;
    item.pos[2]         = pos_2;
    item.pos[3]         = pos_3;
    item.pos[4]         = pos_4;
    item.pos[5]         = pos_5;
    item.unit_signs     = unit_sign_bits;
    item.heavy_pos[0]   = heavy_pos_0;
    item.heavy_pos[1]   = heavy_pos_1;
    item.heavy_pos[2]   = heavy_pos_2;
    item.heavy_neg      = heavy_sign_bits;
  end

  // stage 1: 36 pairs, each reduced to a folded lag and signed product
  snae_pair_stage u_pair (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (item),
    .out_valid (pair_valid),
    .out_ready (pair_ready),
    .out_pairs (pairs)
  );

  // stages 2-3: correlation value of every lag
  snae_lag_accum u_lag (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pair_valid),
    .in_ready  (pair_ready),
    .in_pairs  (pairs),
    .out_valid (lag_valid),
    .out_ready (lag_ready),
    .out_lag   (lags)
  );

  // stages 4-6: squares, sum, window flag, output register
  snae_energy_sum u_energy (
    .clk       (clk),
    .rst       (rst),
    .win       (win),
    .in_valid  (lag_valid),
    .in_ready  (lag_ready),
    .in_lag    (lags),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .energy    (sidelobe_energy),
    .flag      (in_window)
  );

endmodule

`default_nettype wire

// ===== hdl/snae_checker.sv =====
// Port-level checker for the sidelobe energy block, bound to the top level.
// Depends on snae_pkg.
`default_nettype none

module snae_checker import snae_pkg::*; (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire logic [E_W-1:0] sidelobe_energy,
  input wire logic           in_window
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sidelobe_energy) &&
                                $stable(in_window))
    else $error("result changed while stalled");

  // an offered item stays offered until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input item withdrawn before accept");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // with the output free, every stage advances and the input is open
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input blocked while output free");

  // energy bound from the total pair weight
  a_energy_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sidelobe_energy <= E_W'(ENERGY_MAX))
    else $error("energy above bound");

endmodule

bind sparse_negacyclic_autocorr_energy snae_checker u_snae_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .sidelobe_energy (sidelobe_energy),
  .in_window       (in_window)
);

`default_nettype wire
